FILE: hdl/ctpd_pkg.sv
package ctpd_pkg;

   // Field widths fixed by the port definition
   localparam int DATA_BITS = 16;
   localparam int HIT_BITS  = 2;

   // Reset values and press rule
   localparam int BASELINE_RESET  = 8000;
   localparam int THRESHOLD_RESET = 500;
   localparam int HITS_FOR_PRESS  = 3;

   typedef struct packed {
      logic                 pressed;
      logic                 channel;
      logic [DATA_BITS-1:0] baseline;
   } result_type;

endpackage

FILE: hdl/cap_touch_press_detector.sv
// Channel  Direction  Handshake                Payload
// req      in         req_valid / req_ready    req_sample, req_channel
// rsp      out        rsp_valid / rsp_ready    rsp_pressed, rsp_press_channel, rsp_baseline_out
// csr      in         csr_valid / csr_ready    csr_drop_threshold
//
// One transaction per cycle unless rsp stalls; req passes the input then the result register.
// The per-channel baseline and hit count are read and updated in the
// combinational compute step between the input register and the result register.
// Synchronous active-high reset: baselines to 8000, hit counts to zero,
// threshold to 500, both stages empty. csr_ready is always high.
// A stalled rsp holds the result register and backs up into the input register.
module cap_touch_press_detector #(
   parameter int CHANNELS    = 2,
   parameter int SAMPLE_BITS = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [ctpd_pkg::DATA_BITS-1:0] req_sample,
   input  logic                           req_channel,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic                           rsp_pressed,
   output logic                           rsp_press_channel,
   output logic [ctpd_pkg::DATA_BITS-1:0] rsp_baseline_out,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [ctpd_pkg::DATA_BITS-1:0] csr_drop_threshold
);
   import ctpd_pkg::*;

   // input register
   logic                 s1_valid_ff;
   logic [DATA_BITS-1:0] s1_sample_ff;
   logic                 s1_channel_ff;
   // result register
   logic                 rsp_valid_ff;
   result_type           rsp_ff;
   // threshold register
   logic [DATA_BITS-1:0] threshold_ff;

   logic                 advance;
   logic                 req_take;
   result_type           result;

   // advance the input stage when the result register is free or draining
   assign advance   = s1_valid_ff & (~rsp_valid_ff | rsp_ready);
   assign req_ready = ~s1_valid_ff | advance;
   assign req_take  = req_valid & req_ready;
   assign csr_ready = 1'b1;

   ctpd_core #(
      .CHANNELS    (CHANNELS),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .upd_en    (advance),
      .sample    (s1_sample_ff),
      .channel   (s1_channel_ff),
      .threshold (threshold_ff),
      .result    (result)
   );

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         threshold_ff <= DATA_BITS'(THRESHOLD_RESET);
      end else begin
         if (req_ready) begin
            s1_valid_ff <= req_valid;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_valid) begin
            threshold_ff <= csr_drop_threshold;
         end
      end
   end

   // payload: load on take, hold otherwise
   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_sample_ff  <= req_sample;
         s1_channel_ff <= req_channel;
      end
      if (advance) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_pressed       = rsp_ff.pressed;
   assign rsp_press_channel = rsp_ff.channel;
   assign rsp_baseline_out  = rsp_ff.baseline;

endmodule

FILE: hdl/ctpd_core.sv
module ctpd_core #(
   parameter int CHANNELS    = 2,
   parameter int SAMPLE_BITS = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           upd_en,
   input  logic [ctpd_pkg::DATA_BITS-1:0] sample,
   input  logic                           channel,
   input  logic [ctpd_pkg::DATA_BITS-1:0] threshold,
   output ctpd_pkg::result_type           result
);
   import ctpd_pkg::*;

   localparam int IDX_BITS = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int MIX_BITS = SAMPLE_BITS + 5;
   localparam int CMP_BITS = ((SAMPLE_BITS > DATA_BITS) ? SAMPLE_BITS : DATA_BITS) + 1;
   localparam logic [SAMPLE_BITS-1:0] BASE_INIT = SAMPLE_BITS'(BASELINE_RESET);

   logic [SAMPLE_BITS-1:0] baseline_ff [CHANNELS];
   logic [HIT_BITS-1:0]    hit_ff      [CHANNELS];
   logic [SAMPLE_BITS-1:0] baseline_in;
   logic [HIT_BITS-1:0]    hit_in;

   logic [IDX_BITS-1:0]    idx;
   logic                   ch_ok;
   logic [CMP_BITS-1:0]    sample_wide;
   logic [SAMPLE_BITS-1:0] s_use;
   logic [SAMPLE_BITS-1:0] base_cur;
   logic [HIT_BITS-1:0]    hit_cur;
   logic [MIX_BITS-1:0]    mix;
   logic [CMP_BITS-1:0]    low_edge;
   logic                   hit;
   logic [HIT_BITS:0]      hit_sum;
   logic                   full;

   always_comb begin
      idx         = IDX_BITS'(channel);
      ch_ok       = (int'(channel) < CHANNELS);
      // mask the sample to the tracked width
      sample_wide = CMP_BITS'(sample);
      s_use       = sample_wide[SAMPLE_BITS-1:0];
      base_cur    = ch_ok ? baseline_ff[idx] : '0;
      hit_cur     = ch_ok ? hit_ff[idx] : '0;

      // baseline*15 + sample, then divide by 16
      mix         = (MIX_BITS'(base_cur) << 4) - MIX_BITS'(base_cur) + MIX_BITS'(s_use);
      baseline_in = mix[SAMPLE_BITS+3:4];

      // sum formed one bit wider so a large threshold never wraps
      low_edge    = CMP_BITS'(s_use) + CMP_BITS'(threshold);
      hit         = (low_edge < CMP_BITS'(baseline_in));
      hit_sum     = {1'b0, hit_cur} + (HIT_BITS+1)'(1);
      full        = (hit_sum >= (HIT_BITS+1)'(HITS_FOR_PRESS));

      hit_in = hit_cur;
      if (hit) begin
         hit_in = full ? '0 : hit_sum[HIT_BITS-1:0];
      end

      result.pressed  = ch_ok & hit & full;
      result.channel  = channel;
      result.baseline = ch_ok ? DATA_BITS'(baseline_in) : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < CHANNELS; c++) begin
            baseline_ff[c] <= BASE_INIT;
            hit_ff[c]      <= '0;
         end
      end else if (upd_en && ch_ok) begin
         baseline_ff[idx] <= baseline_in;
         hit_ff[idx]      <= hit_in;
      end
   end

endmodule
